/* rtl/core/ppmfg_pkg.sv */
// shared types, codes and reset values for the ppm frame generator
package ppmfg_pkg;

	// item opcodes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_ENABLE       = 3'd0;
	localparam logic [2:0] CFG_ACTIVE_LEVEL = 3'd1;
	localparam logic [2:0] CFG_FRAME_TICKS  = 3'd2;
	localparam logic [2:0] CFG_MARKER_TICKS = 3'd3;
	localparam logic [2:0] CFG_MIN_WIDTH    = 3'd4;
	localparam logic [2:0] CFG_MAX_WIDTH    = 3'd5;
	localparam logic [2:0] CFG_CENTER       = 3'd6;
	localparam logic [2:0] CFG_MIN_REST     = 3'd7;

	// register reset values
	localparam logic        RST_ENABLE       = 1'b1;
	localparam logic        RST_ACTIVE_LEVEL = 1'b1;
	localparam logic [19:0] RST_FRAME_TICKS  = 20'd110000;
	localparam logic [15:0] RST_MARKER_TICKS = 16'd1500;
	localparam logic [19:0] RST_MIN_WIDTH    = 20'd5000;
	localparam logic [19:0] RST_MAX_WIDTH    = 20'd10000;
	localparam logic [19:0] RST_CENTER       = 20'd7500;
	localparam logic [19:0] RST_MIN_REST     = 20'd22500;

	// configuration register file
	typedef struct packed {
		logic        enable;
		logic        active_level;
		logic [19:0] frame_ticks;
		logic [15:0] marker_ticks;
		logic [19:0] min_width_ticks;
		logic [19:0] max_width_ticks;
		logic [19:0] center_ticks;
		logic [19:0] min_rest_ticks;
	} cfg_t;

	// status from the frame builder
	typedef struct packed {
		logic        done;
		logic [15:0] mark;
		logic [19:0] rest_len;
	} bld_stat_t;

	// tick sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_BUILD
	} top_state_t;

	// frame builder states
	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_HALF,
		B_CLAMP,
		B_ACC,
		B_REST
	} bld_state_t;

endpackage

/* rtl/core/ppmfg_frame_builder.sv */
// frame builder: turns latched channel values into slot gaps and the sync rest
module ppmfg_frame_builder #(
	parameter int NUM_CHANNELS = 8,
	parameter int TICKS_PER_US = 5
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  ppmfg_pkg::cfg_t                          cfg,
	input  logic signed [15:0]                       ch_value,
	output logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] ch_sel,
	input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] gap_sel,
	output logic [19:0]                              gap,
	output ppmfg_pkg::bld_stat_t                     stat
);

	localparam int CH_W   = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
	localparam int TPU_W  = $clog2(TICKS_PER_US + 1);
	localparam int PROD_W = 16 + TPU_W + 1;
	localparam int W_W    = (PROD_W > 20 ? PROD_W : 20) + 2;
	localparam int REST_W = 22 + $clog2(NUM_CHANNELS);
	localparam logic signed [PROD_W-1:0] TPU_S = PROD_W'(TICKS_PER_US);

	ppmfg_pkg::bld_state_t state_q, state_d;

	logic [CH_W-1:0]          ch_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [W_W-1:0]    wraw_q;
	logic [19:0]              w_q;
	logic signed [REST_W-1:0] rest_q;
	logic [15:0]              mark_q;
	logic [19:0]              rest_len_q;
	logic [19:0]              gap_q [NUM_CHANNELS];

	logic signed [PROD_W-1:0] prod_adj, half;
	logic signed [W_W-1:0]    center_s, min_s, max_s, wmin, wcl;
	logic signed [20:0]       gdiff;
	logic [19:0]              gap_new;
	logic signed [REST_W-1:0] min_rest_s, rmin;
	logic                     last_ch;

	// signed views of the limits
	assign center_s   = $signed({{(W_W-20){1'b0}}, cfg.center_ticks});
	assign min_s      = $signed({{(W_W-20){1'b0}}, cfg.min_width_ticks});
	assign max_s      = $signed({{(W_W-20){1'b0}}, cfg.max_width_ticks});
	assign min_rest_s = $signed({{(REST_W-20){1'b0}}, cfg.min_rest_ticks});

	// halve the product, rounding toward zero
	assign prod_adj = prod_q + $signed({{(PROD_W-1){1'b0}}, prod_q[PROD_W-1]});
	assign half     = prod_adj >>> 1;

	// clamp to min, then to max
	assign wmin = (wraw_q < min_s) ? min_s : wraw_q;
	assign wcl  = (wmin > max_s) ? max_s : wmin;

	// gap after the marker, at least one tick
	assign gdiff   = $signed({1'b0, w_q}) - $signed({5'b0, cfg.marker_ticks});
	assign gap_new = (gdiff < 21'sd1) ? 20'd1 : gdiff[19:0];

	// rest held at least at the minimum
	assign rmin = (rest_q < min_rest_s) ? min_rest_s : rest_q;

	assign last_ch = (ch_q == CH_W'(NUM_CHANNELS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppmfg_pkg::B_IDLE:  if (start) state_d = ppmfg_pkg::B_MUL;
			ppmfg_pkg::B_MUL:   state_d = ppmfg_pkg::B_HALF;
			ppmfg_pkg::B_HALF:  state_d = ppmfg_pkg::B_CLAMP;
			ppmfg_pkg::B_CLAMP: state_d = ppmfg_pkg::B_ACC;
			ppmfg_pkg::B_ACC:   state_d = last_ch ? ppmfg_pkg::B_REST : ppmfg_pkg::B_MUL;
			ppmfg_pkg::B_REST:  state_d = ppmfg_pkg::B_IDLE;
			default:            state_d = ppmfg_pkg::B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ch_sel        = ch_q;
		gap           = gap_q[gap_sel];
		stat.done     = (state_q == ppmfg_pkg::B_REST);
		stat.mark     = mark_q;
		stat.rest_len = rest_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppmfg_pkg::B_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ppmfg_pkg::B_IDLE && start) begin
				ch_q <= '0;
			end else if (state_q == ppmfg_pkg::B_ACC && !last_ch) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// shared datapath, one step per state
	always_ff @(posedge clk) begin
		unique case (state_q)
			ppmfg_pkg::B_IDLE: begin
				if (start) begin
					rest_q <= $signed({{(REST_W-20){1'b0}}, cfg.frame_ticks});
					mark_q <= (cfg.marker_ticks == 16'd0) ? 16'd1 : cfg.marker_ticks;
				end
			end
			ppmfg_pkg::B_MUL:   prod_q <= PROD_W'(ch_value) * TPU_S;
			ppmfg_pkg::B_HALF:  wraw_q <= W_W'(half) + center_s;
			ppmfg_pkg::B_CLAMP: w_q <= wcl[19:0];
			ppmfg_pkg::B_ACC: begin
				rest_q      <= rest_q - $signed({{(REST_W-20){1'b0}}, w_q});
				gap_q[ch_q] <= gap_new;
			end
			ppmfg_pkg::B_REST: begin
				rest_len_q <= (rmin < REST_W'(1)) ? 20'd1 : rmin[19:0];
			end
			default: ;
		endcase
	end

endmodule

/* rtl/core/ppm_frame_generator.sv */
// ppm frame generator top level: tick sequencer, channel store, config registers
//
//  channel | signals                               | beat taken when
//  --------+---------------------------------------+-------------------------
//  in      | in_valid in_stall op channel_index    | in_valid && !in_stall
//          | channel_value                         |
//  out     | out_valid out_stall ppm_level         | out_valid && !out_stall
//          | frame_start                           |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data| cfg_valid && cfg_ready
//
// a write beat or a tick inside a segment gives its result on the next clock
// a tick that starts a frame waits for the frame build: the shared multiply,
// clamp and accumulate unit walks the channels one after another
// in_stall is high while a frame is built and while a result waits under out_stall
// reset restores the register defaults and clears channel values; the first tick
// starts a frame
module ppm_frame_generator #(
	parameter int NUM_CHANNELS = 8,
	parameter int TICKS_PER_US = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [2:0]         channel_index,
	input  logic signed [15:0] channel_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ppm_level,
	output logic               frame_start,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);

	localparam int CH_W  = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
	localparam int NSEG  = 2 * NUM_CHANNELS + 2;
	localparam int SEG_W = $clog2(NSEG);
	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(NSEG - 1);

	ppmfg_pkg::top_state_t state_q, state_d;
	ppmfg_pkg::cfg_t       cfg_q;
	ppmfg_pkg::bld_stat_t  bld;

	logic signed [15:0] chan_q [NUM_CHANNELS];
	logic               running_q;
	logic [SEG_W-1:0]   seg_idx_q;
	logic [19:0]        ticks_left_q;
	logic               level_q;
	logic               out_valid_q, ppm_level_q, frame_start_q;

	logic               accept, is_tick, need_load, can_adv;
	logic [SEG_W-1:0]   seg_nxt;
	logic [CH_W-1:0]    ch_sel, gap_sel, wr_idx;
	logic [19:0]        gap, len_nxt;
	logic               act_write, act_count, act_adv, act_build, act_stop, act_frame;
	logic               res_valid, res_level, res_fs;

	ppmfg_frame_builder #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.TICKS_PER_US(TICKS_PER_US)
	) u_builder (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (act_build),
		.cfg     (cfg_q),
		.ch_value(chan_q[ch_sel]),
		.ch_sel  (ch_sel),
		.gap_sel (gap_sel),
		.gap     (gap),
		.stat    (bld)
	);

	// handshake
	assign in_stall  = (state_q != ppmfg_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign ppm_level = ppm_level_q;
	assign frame_start = frame_start_q;
	assign cfg_ready = 1'b1;

	// segment bookkeeping
	assign is_tick   = (op == ppmfg_pkg::OP_TICK);
	assign need_load = !running_q || (ticks_left_q == 20'd0);
	assign can_adv   = running_q && (seg_idx_q != SEG_LAST);
	assign seg_nxt   = seg_idx_q + 1'b1;
	assign gap_sel   = CH_W'(seg_nxt >> 1);
	assign wr_idx    = CH_W'(channel_index);

	// length of the segment about to start
	always_comb begin
		priority if (!seg_nxt[0]) begin
			len_nxt = {4'b0, bld.mark};
		end else if (seg_nxt == SEG_LAST) begin
			len_nxt = bld.rest_len;
		end else begin
			len_nxt = gap;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppmfg_pkg::ST_IDLE:  if (act_build) state_d = ppmfg_pkg::ST_BUILD;
			ppmfg_pkg::ST_BUILD: if (bld.done) state_d = ppmfg_pkg::ST_IDLE;
			default:             state_d = ppmfg_pkg::ST_IDLE;
		endcase
	end

	// actions and result
	always_comb begin
		act_write = 1'b0;
		act_count = 1'b0;
		act_adv   = 1'b0;
		act_build = 1'b0;
		act_stop  = 1'b0;
		act_frame = 1'b0;
		res_level = level_q;
		res_fs    = 1'b0;
		unique case (state_q)
			ppmfg_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (!is_tick) begin
						act_write = 1'b1;
					end else if (!need_load) begin
						act_count = 1'b1;
					end else if (can_adv) begin
						act_adv   = 1'b1;
						res_level = seg_nxt[0] ? !cfg_q.active_level : cfg_q.active_level;
					end else if (cfg_q.enable) begin
						act_build = 1'b1;
					end else begin
						act_stop  = 1'b1;
						res_level = cfg_q.active_level;
					end
				end
			end
			ppmfg_pkg::ST_BUILD: begin
				if (bld.done) begin
					act_frame = 1'b1;
					res_level = cfg_q.active_level;
					res_fs    = 1'b1;
				end
			end
			default: ;
		endcase
		res_valid = act_write || act_count || act_adv || act_stop || act_frame;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= ppmfg_pkg::RST_ENABLE;
			cfg_q.active_level    <= ppmfg_pkg::RST_ACTIVE_LEVEL;
			cfg_q.frame_ticks     <= ppmfg_pkg::RST_FRAME_TICKS;
			cfg_q.marker_ticks    <= ppmfg_pkg::RST_MARKER_TICKS;
			cfg_q.min_width_ticks <= ppmfg_pkg::RST_MIN_WIDTH;
			cfg_q.max_width_ticks <= ppmfg_pkg::RST_MAX_WIDTH;
			cfg_q.center_ticks    <= ppmfg_pkg::RST_CENTER;
			cfg_q.min_rest_ticks  <= ppmfg_pkg::RST_MIN_REST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppmfg_pkg::CFG_ENABLE:       cfg_q.enable          <= cfg_data[0];
				ppmfg_pkg::CFG_ACTIVE_LEVEL: cfg_q.active_level    <= cfg_data[0];
				ppmfg_pkg::CFG_FRAME_TICKS:  cfg_q.frame_ticks     <= cfg_data;
				ppmfg_pkg::CFG_MARKER_TICKS: cfg_q.marker_ticks    <= cfg_data[15:0];
				ppmfg_pkg::CFG_MIN_WIDTH:    cfg_q.min_width_ticks <= cfg_data;
				ppmfg_pkg::CFG_MAX_WIDTH:    cfg_q.max_width_ticks <= cfg_data;
				ppmfg_pkg::CFG_CENTER:       cfg_q.center_ticks    <= cfg_data;
				ppmfg_pkg::CFG_MIN_REST:     cfg_q.min_rest_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	// channel value store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chan_q[i] <= '0;
			end
		end else if (act_write && (32'(channel_index) < NUM_CHANNELS)) begin
			chan_q[wr_idx] <= channel_value;
		end
	end

	// segment sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ppmfg_pkg::ST_IDLE;
			running_q    <= 1'b0;
			seg_idx_q    <= '0;
			ticks_left_q <= '0;
			level_q      <= ppmfg_pkg::RST_ACTIVE_LEVEL;
		end else begin
			state_q <= state_d;
			priority if (act_count) begin
				ticks_left_q <= ticks_left_q - 1'b1;
			end else if (act_adv) begin
				seg_idx_q    <= seg_nxt;
				ticks_left_q <= len_nxt - 1'b1;
				level_q      <= res_level;
			end else if (act_frame) begin
				seg_idx_q    <= '0;
				running_q    <= 1'b1;
				ticks_left_q <= {4'b0, bld.mark} - 1'b1;
				level_q      <= res_level;
			end else if (act_stop) begin
				running_q <= 1'b0;
				level_q   <= res_level;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			ppm_level_q   <= res_level;
			frame_start_q <= res_fs;
		end
	end

`ifndef NO_ASSERTIONS
	// no new beat while a frame is being built
	a_stall_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppmfg_pkg::ST_BUILD |-> in_stall)
		else $error("input taken during frame build");

	// builder finishes only when the sequencer waits for it
	a_done_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		bld.done |-> state_q == ppmfg_pkg::ST_BUILD)
		else $error("frame build done outside build state");

	// a frame only begins out of a build
	a_run_from_build: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(running_q) |-> $past(state_q == ppmfg_pkg::ST_BUILD))
		else $error("frame started without a build");

	// a frame start beat is always inside a running frame
	a_fs_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_start_q |-> running_q)
		else $error("frame start result while not running");

	// a held result is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !res_valid)
		else $error("result overwritten while stalled");
`endif

endmodule

/* verif/ppm_frame_generator_tb.sv */
// self-checking testbench for the ppm frame generator: directed table, then random phases
module ppm_frame_generator_tb;

	localparam int NUM_CH       = 8;
	localparam int TICKS_PER_US = 5;
	localparam int NUM_SEGS     = 2 * NUM_CH + 2;
	localparam int NUM_PHASES   = 6;
	localparam int PHASE_ITEMS  = 65;
	localparam int LONG_HOLD    = 150;
	localparam longint RUN_LIMIT = 64'd8000000;

	// one output beat
	typedef struct packed {
		logic level;
		logic fs;
	} pulse_t;

	typedef enum logic [1:0] {
		ROW_TICK,
		ROW_WRITE,
		ROW_CFG
	} row_kind_t;

	// directed row: channel or register index, value, repeat count, optional fixed result
	typedef struct {
		row_kind_t   kind;
		logic [2:0]  sel;
		logic [19:0] data;
		int unsigned reps;
		bit          typed;
		logic        exp_level;
		logic        exp_fs;
	} plan_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = ppmfg_pkg::OP_TICK;
	logic [2:0] channel_index = '0;
	logic signed [15:0] channel_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic ppm_level;
	logic frame_start;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;

	// predicted pulse train state
	ppmfg_pkg::cfg_t shadow = '{ppmfg_pkg::RST_ENABLE, ppmfg_pkg::RST_ACTIVE_LEVEL,
		ppmfg_pkg::RST_FRAME_TICKS, ppmfg_pkg::RST_MARKER_TICKS, ppmfg_pkg::RST_MIN_WIDTH,
		ppmfg_pkg::RST_MAX_WIDTH, ppmfg_pkg::RST_CENTER, ppmfg_pkg::RST_MIN_REST};
	logic signed [15:0] chan_val [NUM_CH] = '{default: '0};
	logic [19:0] seg_len [NUM_SEGS] = '{default: '0};
	logic [4:0] seg_idx = '0;
	logic [19:0] ticks_left = '0;
	logic level = ppmfg_pkg::RST_ACTIVE_LEVEL;
	bit running = 1'b0;

	pulse_t pending_pulses [$];
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit hold_req = 1'b0;

	plan_row_t plan [];
	ppmfg_pkg::cfg_t phase_cfg [NUM_PHASES];

	ppm_frame_generator #(
		.NUM_CHANNELS(NUM_CH),
		.TICKS_PER_US(TICKS_PER_US)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ppm_level    (ppm_level),
		.frame_start  (frame_start),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// turn latched channel values into marker, gap and rest lengths
	function automatic void latch_frame();
		longint rest, mark, w, gap, lo, hi, rest_floor;
		int i;
		rest = shadow.frame_ticks;
		mark = (shadow.marker_ticks == 0) ? 1 : shadow.marker_ticks;
		lo = shadow.min_width_ticks;
		hi = shadow.max_width_ticks;
		rest_floor = shadow.min_rest_ticks;
		for (i = 0; i < NUM_CH; i++) begin
			w = (longint'(chan_val[i]) * TICKS_PER_US) / 2 + longint'(shadow.center_ticks);
			// upper limit wins when the limits cross
			if (w < lo) w = lo;
			if (w > hi) w = hi;
			rest -= w;
			gap = w - longint'(shadow.marker_ticks);
			if (gap < 1) gap = 1;
			seg_len[2 * i] = 20'(mark);
			seg_len[2 * i + 1] = 20'(gap);
		end
		if (rest < rest_floor) rest = rest_floor;
		if (rest < 1) rest = 1;
		seg_len[NUM_SEGS - 2] = 20'(mark);
		seg_len[NUM_SEGS - 1] = 20'(rest);
	endfunction

	// advance the predicted train by one input beat
	function automatic pulse_t next_pulse(logic o, logic [2:0] ci, logic signed [15:0] cv);
		pulse_t p;
		p.fs = 1'b0;
		if (o == ppmfg_pkg::OP_WRITE) begin
			if (ci < NUM_CH) chan_val[ci] = cv;
			p.level = level;
			return p;
		end
		if (!running || ticks_left == 0) begin
			if (running && int'(seg_idx) + 1 < NUM_SEGS) begin
				seg_idx = seg_idx + 1'b1;
			end else if (shadow.enable) begin
				latch_frame();
				seg_idx = '0;
				running = 1'b1;
				p.fs = 1'b1;
			end else begin
				// frame over and disabled: idle at the active level
				running = 1'b0;
				level = shadow.active_level;
				p.level = level;
				return p;
			end
			ticks_left = (seg_len[seg_idx] == 0) ? 20'd1 : seg_len[seg_idx];
			level = seg_idx[0] ? ~shadow.active_level : shadow.active_level;
		end
		ticks_left = ticks_left - 1'b1;
		p.level = level;
		return p;
	endfunction

	// block until every expected beat has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pulses.size() != 0) @(posedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic write_reg(input logic [2:0] rsel, input logic [19:0] rdata);
		bit taken;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= rsel;
		cfg_data <= rdata;
		do begin
			@(negedge clk);
			taken = (cfg_ready === 1'b1);
			@(posedge clk);
		end while (!taken);
		case (rsel)
			ppmfg_pkg::CFG_ENABLE:       shadow.enable = rdata[0];
			ppmfg_pkg::CFG_ACTIVE_LEVEL: shadow.active_level = rdata[0];
			ppmfg_pkg::CFG_FRAME_TICKS:  shadow.frame_ticks = rdata;
			ppmfg_pkg::CFG_MARKER_TICKS: shadow.marker_ticks = rdata[15:0];
			ppmfg_pkg::CFG_MIN_WIDTH:    shadow.min_width_ticks = rdata;
			ppmfg_pkg::CFG_MAX_WIDTH:    shadow.max_width_ticks = rdata;
			ppmfg_pkg::CFG_CENTER:       shadow.center_ticks = rdata;
			ppmfg_pkg::CFG_MIN_REST:     shadow.min_rest_ticks = rdata;
			default: ;
		endcase
	endtask

	// offer one input beat; record the fixed or predicted result once it is taken
	task automatic offer_item(input logic o, input logic [2:0] ci, input logic signed [15:0] cv,
			input bit typed, input pulse_t typed_exp);
		bit taken;
		pulse_t want;
		if (cfg_valid) cfg_valid <= 1'b0;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		channel_index <= ci;
		channel_value <= cv;
		do begin
			@(negedge clk);
			taken = (in_stall === 1'b0);
			@(posedge clk);
		end while (!taken);
		want = next_pulse(o, ci, cv);
		pending_pulses.push_back(typed ? typed_exp : want);
	endtask

	// output side: sample at the falling edge, take the beat at the rising edge
	initial begin : receiver
		logic r_fire, r_lvl, r_fs;
		pulse_t want;
		int unsigned hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(negedge clk);
			r_fire = arst_n && (out_valid === 1'b1) && !out_stall;
			r_lvl = ppm_level;
			r_fs = frame_start;
			@(posedge clk);
			if (r_fire) begin
				if (pending_pulses.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with none expected, ppm_level %0b frame_start %0b",
						$time, r_lvl, r_fs);
				end else begin
					want = pending_pulses.pop_front();
					if (r_lvl !== want.level) begin
						mismatches++;
						$display("%0t: ppm_level expected %0b actual %0b",
							$time, want.level, r_lvl);
					end
					if (r_fs !== want.fs) begin
						mismatches++;
						$display("%0t: frame_start expected %0b actual %0b",
							$time, want.fs, r_fs);
					end
				end
			end
			// one long hold-off so the block backs up into in_stall
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int unsigned k, n, ph, s;
		logic [2:0] ci;
		logic signed [15:0] cv;
		ppmfg_pkg::cfg_t c;

		// kind, index, data, reps, typed, level, frame_start
		plan = '{
			// writes before any tick hold the reset idle level; value extremes
			'{ROW_WRITE, 3'd0, 20'h07fff, 1, 1'b1, 1'b1, 1'b0},
			'{ROW_WRITE, 3'd7, 20'h08000, 1, 1'b1, 1'b1, 1'b0},
			// zero marker, crossed width limits, width not above marker, zero rest
			'{ROW_CFG, ppmfg_pkg::CFG_ENABLE, 20'd0, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_MARKER_TICKS, 20'd0, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_FRAME_TICKS, 20'd0, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_MIN_WIDTH, 20'd3, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_MAX_WIDTH, 20'd0, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_CENTER, 20'd1, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_MIN_REST, 20'd0, 0, 1'b0, 1'b0, 1'b0},
			// disabled: no frame, idles at active level
			'{ROW_TICK, 3'd0, 20'd0, 1, 1'b1, 1'b1, 1'b0},
			'{ROW_CFG, ppmfg_pkg::CFG_ACTIVE_LEVEL, 20'd0, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_TICK, 3'd5, 20'hfffff, 1, 1'b1, 1'b0, 1'b0},
			'{ROW_WRITE, 3'd3, 20'h0ffff, 1, 1'b1, 1'b0, 1'b0},
			// re-enable: frame starts on the next tick
			'{ROW_CFG, ppmfg_pkg::CFG_ENABLE, 20'd1, 0, 1'b0, 1'b0, 1'b0},
			'{ROW_TICK, 3'd0, 20'd0, 1, 1'b1, 1'b0, 1'b1},
			'{ROW_TICK, 3'd0, 20'd0, 1, 1'b1, 1'b1, 1'b0},
			// rest of the one-tick segments and the next frame start
			'{ROW_TICK, 3'd2, 20'd0, 17, 1'b0, 1'b0, 1'b0}
		};

		// enable, active, frame, marker, min width, max width, center, min rest
		phase_cfg[0] = '{1'b1, 1'b1, 20'd10, 16'd1, 20'd1, 20'd5, 20'd3, 20'd2};
		phase_cfg[1] = '{1'b1, 1'b0, 20'd0, 16'd1, 20'd0, 20'd4, 20'd2, 20'd0};
		phase_cfg[2] = '{1'b0, 1'b1, 20'd12, 16'd3, 20'd2, 20'd6, 20'd4, 20'd5};
		phase_cfg[3] = '{1'b1, 1'b1, 20'd0, 16'd0, 20'd0, 20'd0, 20'd0, 20'd0};
		phase_cfg[4] = '{1'b1, 1'b0, 20'd20, 16'd2, 20'd7, 20'd2, 20'd5, 20'd1};
		phase_cfg[5] = '{1'b1, 1'b1, 20'hfffff, 16'hffff, 20'hfffff, 20'hfffff,
			20'hfffff, 20'hfffff};

		send_idle_pct = 12;
		recv_idle_pct = 67;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (k = 0; k < plan.size(); k++) begin
			if (plan[k].kind == ROW_CFG) begin
				write_reg(plan[k].sel, plan[k].data);
			end else begin
				for (n = 0; n < plan[k].reps; n++)
					offer_item((plan[k].kind == ROW_WRITE) ? ppmfg_pkg::OP_WRITE
						: ppmfg_pkg::OP_TICK, plan[k].sel, plan[k].data[15:0],
						plan[k].typed, {plan[k].exp_level, plan[k].exp_fs});
			end
		end

		// random phases, each with its own register setting and idle pattern
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 67 : 0;
			recv_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 12 : 0;
			c = phase_cfg[ph];
			write_reg(ppmfg_pkg::CFG_ENABLE, 20'(c.enable));
			write_reg(ppmfg_pkg::CFG_ACTIVE_LEVEL, 20'(c.active_level));
			write_reg(ppmfg_pkg::CFG_FRAME_TICKS, c.frame_ticks);
			write_reg(ppmfg_pkg::CFG_MARKER_TICKS, 20'(c.marker_ticks));
			write_reg(ppmfg_pkg::CFG_MIN_WIDTH, c.min_width_ticks);
			write_reg(ppmfg_pkg::CFG_MAX_WIDTH, c.max_width_ticks);
			write_reg(ppmfg_pkg::CFG_CENTER, c.center_ticks);
			write_reg(ppmfg_pkg::CFG_MIN_REST, c.min_rest_ticks);
			if (ph == 1) hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(99) < 25) begin
					ci = 3'($urandom_range(7));
					// half full range, half near zero so widths land inside the limits
					if ($urandom_range(1) == 0) begin
						cv = 16'($urandom);
					end else begin
						s = $urandom_range(12);
						cv = 16'(int'(s) - 6);
					end
					offer_item(ppmfg_pkg::OP_WRITE, ci, cv, 1'b0, '0);
				end else begin
					// payload is don't-care on ticks
					ci = 3'($urandom);
					cv = 16'($urandom);
					offer_item(ppmfg_pkg::OP_TICK, ci, cv, 1'b0, '0);
				end
			end
		end

		wait_drained();
		repeat (4 * NUM_CH + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
